[rtl/core/tapq_pkg.sv]
// tapq_pkg: shared constants, request classes, queue entry and sequencer states
// for the tree ancestor path query block. No dependencies.
`default_nettype none
package tapq_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 11;
  localparam int EDGE_CAP    = 2 * (MAX_NODES - 1);
  localparam int NODE_W      = 11;
  localparam int LVL_W       = 4;
  localparam int ANC_AW      = LVL_W + NODE_W;
  localparam int ANC_DEPTH   = LIFT_LEVELS * (1 << NODE_W);
  localparam int STK_AW      = 10;

  typedef enum logic [1:0] {
    CL_EDGE,
    CL_EDGE_DROP,
    CL_QUERY,
    CL_QUERY_BAD
  } tapq_cls_t;

  typedef struct packed {
    tapq_cls_t           cls;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [31:0]         w;
  } tapq_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_E_WA,
    ST_E_WB,
    ST_B_INIT,
    ST_B_HEAD,
    ST_B_EDGE,
    ST_B_TGT,
    ST_B_CHK,
    ST_B_POP,
    ST_B_POP2,
    ST_F_RD1,
    ST_F_RD2,
    ST_F_WR,
    ST_Q_START,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_UP,
    ST_Q_UPD,
    ST_Q_CMP,
    ST_Q_SUM,
    ST_Q_SB,
    ST_Q_SA,
    ST_Q_OUT
  } tapq_state_t;

endpackage
`default_nettype wire

[rtl/core/tapq_front.sv]
// tapq_front: node count register, request classification and a two-entry
// queue towards the back end. Depends on tapq_pkg.
`default_nettype none
module tapq_front (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire                            in_mode,
  input  wire  [tapq_pkg::NODE_W-1:0]    in_node_a,
  input  wire  [tapq_pkg::NODE_W-1:0]    in_node_b,
  input  wire  [31:0]                    in_weight,
  input  wire                            cfg_we,
  input  wire  [tapq_pkg::NODE_W-1:0]    cfg_wdata,
  input  wire                            back_clearing,
  input  wire                            q_pop,
  output logic                           q_valid,
  output tapq_pkg::tapq_item_t           q_item
);

  logic [tapq_pkg::NODE_W-1:0] nc_r;
  logic [tapq_pkg::NODE_W-1:0] n_eff;
  tapq_pkg::tapq_item_t        q_mem_r [0:1];
  logic                        wp_r, rp_r;
  logic [1:0]                  cnt_r;
  logic                        push, bad;
  tapq_pkg::tapq_item_t        new_item;

  assign n_eff = (nc_r > tapq_pkg::NODE_W'(tapq_pkg::MAX_NODES)) ?
                 tapq_pkg::NODE_W'(tapq_pkg::MAX_NODES) : nc_r;
  assign bad   = (in_node_a == '0) || (in_node_b == '0) ||
                 (in_node_a > n_eff) || (in_node_b > n_eff);

  always_comb begin
    new_item.a = in_node_a;
    new_item.b = in_node_b;
    new_item.w = in_weight;
    if (in_mode) begin
      new_item.cls = bad ? tapq_pkg::CL_QUERY_BAD : tapq_pkg::CL_QUERY;
    end else begin
      new_item.cls = bad ? tapq_pkg::CL_EDGE_DROP : tapq_pkg::CL_EDGE;
    end
  end

  assign busy    = (cnt_r == 2'd2) || back_clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r  <= tapq_pkg::NODE_W'(1);
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (cfg_we) begin
        nc_r <= cfg_wdata;
      end
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop && q_valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule
`default_nettype wire

[rtl/core/tapq_back.sv]
// tapq_back: clearing pass, edge store, depth-first build, lifting table fill
// and ancestor queries, with all memories. Depends on tapq_pkg.
`default_nettype none
module tapq_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            q_valid,
  input  tapq_pkg::tapq_item_t           q_item,
  output logic                           q_pop,
  output logic                           clearing,
  output logic                           out_valid,
  output logic                           out_on_path,
  output logic signed [63:0]             out_path_length,
  output logic [31:0]                    out_match_count,
  output logic signed [63:0]             out_total_length
);

  localparam int NW = tapq_pkg::NODE_W;
  localparam int LW = tapq_pkg::LVL_W;
  localparam int AW = tapq_pkg::ANC_AW;
  localparam int SW = tapq_pkg::STK_AW;

  // memories
  logic [NW-1:0] head_mem [0:tapq_pkg::MAX_NODES];
  logic [NW-1:0] tgt_mem  [0:tapq_pkg::EDGE_CAP];
  logic [NW-1:0] nxt_mem  [0:tapq_pkg::EDGE_CAP];
  logic [31:0]   len_mem  [0:tapq_pkg::EDGE_CAP];
  logic [NW-1:0] dep_mem  [0:tapq_pkg::MAX_NODES];
  logic [63:0]   sum_mem  [0:tapq_pkg::MAX_NODES];
  logic [NW-1:0] anc_mem  [0:tapq_pkg::ANC_DEPTH-1];
  logic [NW-1:0] stku_mem [0:(1<<SW)-1];
  logic [NW-1:0] stke_mem [0:(1<<SW)-1];

  logic          head_we, edge_we, dep_we, sum_we, anc_we, stk_we;
  logic [NW-1:0] head_wa, head_wd, head_ra, head_rd;
  logic [NW-1:0] edge_wa, tgt_wd, nxt_wd, edge_ra, tgt_rd, nxt_rd;
  logic [31:0]   len_wd, len_rd;
  logic [NW-1:0] dep_wa, dep_wd, dep_ra, dep_rd;
  logic [NW-1:0] sum_wa, sum_ra;
  logic [63:0]   sum_wd, sum_rd;
  logic [AW-1:0] anc_wa, anc_ra;
  logic [NW-1:0] anc_wd, anc_rd;
  logic [SW-1:0] stk_wa, stk_ra;
  logic [NW-1:0] stku_wd, stke_wd, stku_rd, stke_rd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (edge_we) begin
      tgt_mem[edge_wa] <= tgt_wd;
      nxt_mem[edge_wa] <= nxt_wd;
      len_mem[edge_wa] <= len_wd;
    end
    tgt_rd <= tgt_mem[edge_ra];
    nxt_rd <= nxt_mem[edge_ra];
    len_rd <= len_mem[edge_ra];
  end
  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_wa] <= dep_wd;
    dep_rd <= dep_mem[dep_ra];
  end
  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd <= sum_mem[sum_ra];
  end
  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_wa] <= anc_wd;
    anc_rd <= anc_mem[anc_ra];
  end
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stku_mem[stk_wa] <= stku_wd;
      stke_mem[stk_wa] <= stke_wd;
    end
    stku_rd <= stku_mem[stk_ra];
    stke_rd <= stke_mem[stk_ra];
  end

  // sequencer registers
  tapq_pkg::tapq_state_t state_r, state_nxt;
  tapq_pkg::tapq_item_t  item_r, item_nxt;
  logic [NW-1:0] clr_r, clr_nxt, ec_r, ec_nxt, top_r, top_nxt;
  logic          built_r, built_nxt;
  logic [NW-1:0] cur_u_r, cur_u_nxt, cur_e_r, cur_e_nxt, cur_d_r, cur_d_nxt;
  logic [63:0]   cur_sum_r, cur_sum_nxt, w_r, w_nxt;
  logic [NW-1:0] v_r, v_nxt, fi_r, fi_nxt;
  logic [LW-1:0] fj_r, fj_nxt, lv_r, lv_nxt;
  logic [NW-1:0] da_r, da_nxt, x_r, x_nxt, up_r, up_nxt;
  logic [63:0]   sb_r, sb_nxt, plen_r, plen_nxt, tot_r, tot_nxt;
  logic          hit_r, hit_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt, oh_r, oh_nxt;
  logic [63:0]   opl_r, opl_nxt;

  logic [NW-1:0] e1, e2;
  logic          cap_full;
  assign e1       = ec_r + NW'(1);
  assign e2       = ec_r + NW'(2);
  assign cap_full = ({1'b0, ec_r} + (NW+1)'(2)) > (NW+1)'(tapq_pkg::EDGE_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tapq_pkg::ST_CLEAR;
      clr_r   <= '0;
      ec_r    <= '0;
      top_r   <= '0;
      built_r <= 1'b0;
      cnt_r   <= '0;
      tot_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ec_r    <= ec_nxt;
      top_r   <= top_nxt;
      built_r <= built_nxt;
      cnt_r   <= cnt_nxt;
      tot_r   <= tot_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cur_u_r   <= cur_u_nxt;
    cur_e_r   <= cur_e_nxt;
    cur_d_r   <= cur_d_nxt;
    cur_sum_r <= cur_sum_nxt;
    w_r       <= w_nxt;
    v_r       <= v_nxt;
    fi_r      <= fi_nxt;
    fj_r      <= fj_nxt;
    lv_r      <= lv_nxt;
    da_r      <= da_nxt;
    x_r       <= x_nxt;
    up_r      <= up_nxt;
    sb_r      <= sb_nxt;
    plen_r    <= plen_nxt;
    hit_r     <= hit_nxt;
    oh_r      <= oh_nxt;
    opl_r     <= opl_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    clr_nxt = clr_r; ec_nxt = ec_r; top_nxt = top_r; built_nxt = built_r;
    cur_u_nxt = cur_u_r; cur_e_nxt = cur_e_r; cur_d_nxt = cur_d_r;
    cur_sum_nxt = cur_sum_r; w_nxt = w_r; v_nxt = v_r;
    fi_nxt = fi_r; fj_nxt = fj_r; lv_nxt = lv_r;
    da_nxt = da_r; x_nxt = x_r; up_nxt = up_r;
    sb_nxt = sb_r; plen_nxt = plen_r; hit_nxt = hit_r;
    cnt_nxt = cnt_r; tot_nxt = tot_r;
    ov_nxt = 1'b0; oh_nxt = oh_r; opl_nxt = opl_r;
    q_pop = 1'b0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    edge_we = 1'b0; edge_wa = '0; tgt_wd = '0; nxt_wd = '0; len_wd = '0; edge_ra = '0;
    dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_ra = '0;
    sum_we = 1'b0; sum_wa = '0; sum_wd = '0; sum_ra = '0;
    anc_we = 1'b0; anc_wa = '0; anc_wd = '0; anc_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stku_wd = '0; stke_wd = '0; stk_ra = '0;

    case (state_r)
      tapq_pkg::ST_CLEAR: begin
        head_we = 1'b1; head_wa = clr_r;
        dep_we  = 1'b1; dep_wa  = clr_r;
        sum_we  = 1'b1; sum_wa  = clr_r;
        anc_we  = 1'b1; anc_wa  = {LW'(0), clr_r};
        if (clr_r == NW'(tapq_pkg::MAX_NODES)) begin
          state_nxt = tapq_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      tapq_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          head_ra  = q_item.a;
          case (q_item.cls)
            tapq_pkg::CL_EDGE: begin
              if (!built_r && !cap_full) state_nxt = tapq_pkg::ST_E_WA;
            end
            tapq_pkg::CL_EDGE_DROP: state_nxt = tapq_pkg::ST_IDLE;
            default: begin
              state_nxt = built_r ? tapq_pkg::ST_Q_START : tapq_pkg::ST_B_INIT;
            end
          endcase
        end
      end
      tapq_pkg::ST_E_WA: begin
        edge_we = 1'b1; edge_wa = e1;
        tgt_wd = item_r.b; nxt_wd = head_rd; len_wd = item_r.w;
        head_we = 1'b1; head_wa = item_r.a; head_wd = e1;
        head_ra = item_r.b;
        state_nxt = tapq_pkg::ST_E_WB;
      end
      tapq_pkg::ST_E_WB: begin
        edge_we = 1'b1; edge_wa = e2;
        tgt_wd = item_r.a; len_wd = item_r.w;
        nxt_wd = (item_r.a == item_r.b) ? e1 : head_rd;
        head_we = 1'b1; head_wa = item_r.b; head_wd = e2;
        ec_nxt = e2;
        state_nxt = tapq_pkg::ST_IDLE;
      end
      tapq_pkg::ST_B_INIT: begin
        dep_we = 1'b1; dep_wa = NW'(1); dep_wd = NW'(1);
        head_ra = NW'(1);
        cur_u_nxt = NW'(1); cur_d_nxt = NW'(1); cur_sum_nxt = '0;
        top_nxt = NW'(1);
        state_nxt = tapq_pkg::ST_B_HEAD;
      end
      tapq_pkg::ST_B_HEAD: begin
        cur_e_nxt = head_rd;
        state_nxt = tapq_pkg::ST_B_EDGE;
      end
      tapq_pkg::ST_B_EDGE: begin
        if (cur_e_r == '0) begin
          if (top_r == NW'(1)) begin
            top_nxt = '0;
            fj_nxt = LW'(1); fi_nxt = NW'(1);
            state_nxt = tapq_pkg::ST_F_RD1;
          end else begin
            top_nxt = top_r - NW'(1);
            stk_ra = SW'(top_r - NW'(2));
            state_nxt = tapq_pkg::ST_B_POP;
          end
        end else begin
          edge_ra = cur_e_r;
          state_nxt = tapq_pkg::ST_B_TGT;
        end
      end
      tapq_pkg::ST_B_TGT: begin
        v_nxt = tgt_rd;
        w_nxt = {{32{len_rd[31]}}, len_rd};
        cur_e_nxt = nxt_rd;
        dep_ra = tgt_rd;
        state_nxt = tapq_pkg::ST_B_CHK;
      end
      tapq_pkg::ST_B_CHK: begin
        if (dep_rd != '0) begin
          state_nxt = tapq_pkg::ST_B_EDGE;
        end else begin
          anc_we = 1'b1; anc_wa = {LW'(0), v_r}; anc_wd = cur_u_r;
          dep_we = 1'b1; dep_wa = v_r; dep_wd = cur_d_r + NW'(1);
          sum_we = 1'b1; sum_wa = v_r; sum_wd = cur_sum_r + w_r;
          stk_we = 1'b1; stk_wa = SW'(top_r - NW'(1));
          stku_wd = cur_u_r; stke_wd = cur_e_r;
          cur_u_nxt = v_r; cur_d_nxt = cur_d_r + NW'(1);
          cur_sum_nxt = cur_sum_r + w_r;
          top_nxt = top_r + NW'(1);
          head_ra = v_r;
          state_nxt = tapq_pkg::ST_B_HEAD;
        end
      end
      tapq_pkg::ST_B_POP: begin
        cur_u_nxt = stku_rd; cur_e_nxt = stke_rd;
        dep_ra = stku_rd; sum_ra = stku_rd;
        state_nxt = tapq_pkg::ST_B_POP2;
      end
      tapq_pkg::ST_B_POP2: begin
        cur_d_nxt = dep_rd; cur_sum_nxt = sum_rd;
        state_nxt = tapq_pkg::ST_B_EDGE;
      end
      tapq_pkg::ST_F_RD1: begin
        anc_ra = {fj_r - LW'(1), fi_r};
        state_nxt = tapq_pkg::ST_F_RD2;
      end
      tapq_pkg::ST_F_RD2, tapq_pkg::ST_F_WR: begin
        if (state_r == tapq_pkg::ST_F_RD2 && anc_rd != '0) begin
          anc_ra = {fj_r - LW'(1), anc_rd};
          state_nxt = tapq_pkg::ST_F_WR;
        end else begin
          // null ancestor stays null
          anc_we = 1'b1; anc_wa = {fj_r, fi_r};
          anc_wd = (state_r == tapq_pkg::ST_F_WR) ? anc_rd : '0;
          if (fi_r == NW'(tapq_pkg::MAX_NODES)) begin
            if (fj_r == LW'(tapq_pkg::LIFT_LEVELS - 1)) begin
              built_nxt = 1'b1;
              state_nxt = tapq_pkg::ST_Q_START;
            end else begin
              fj_nxt = fj_r + LW'(1); fi_nxt = NW'(1);
              state_nxt = tapq_pkg::ST_F_RD1;
            end
          end else begin
            fi_nxt = fi_r + NW'(1);
            state_nxt = tapq_pkg::ST_F_RD1;
          end
        end
      end
      tapq_pkg::ST_Q_START: begin
        hit_nxt = 1'b0; plen_nxt = '0;
        if (item_r.cls == tapq_pkg::CL_QUERY_BAD) begin
          state_nxt = tapq_pkg::ST_Q_OUT;
        end else begin
          dep_ra = item_r.a;
          state_nxt = tapq_pkg::ST_Q_DA;
        end
      end
      tapq_pkg::ST_Q_DA: begin
        da_nxt = dep_rd;
        dep_ra = item_r.b;
        state_nxt = tapq_pkg::ST_Q_DB;
      end
      tapq_pkg::ST_Q_DB: begin
        if (da_r == '0 || dep_rd == '0 || da_r > dep_rd) begin
          state_nxt = tapq_pkg::ST_Q_OUT;
        end else begin
          x_nxt = item_r.b;
          lv_nxt = LW'(tapq_pkg::LIFT_LEVELS - 1);
          state_nxt = tapq_pkg::ST_Q_UP;
        end
      end
      tapq_pkg::ST_Q_UP: begin
        anc_ra = {lv_r, x_r};
        state_nxt = tapq_pkg::ST_Q_UPD;
      end
      tapq_pkg::ST_Q_UPD: begin
        up_nxt = anc_rd;
        dep_ra = anc_rd;
        state_nxt = tapq_pkg::ST_Q_CMP;
      end
      tapq_pkg::ST_Q_CMP: begin
        if (dep_rd >= da_r) x_nxt = up_r;
        if (lv_r == '0) begin
          state_nxt = tapq_pkg::ST_Q_SUM;
        end else begin
          lv_nxt = lv_r - LW'(1);
          state_nxt = tapq_pkg::ST_Q_UP;
        end
      end
      tapq_pkg::ST_Q_SUM: begin
        if (x_r == item_r.a) begin
          sum_ra = item_r.b;
          state_nxt = tapq_pkg::ST_Q_SB;
        end else begin
          state_nxt = tapq_pkg::ST_Q_OUT;
        end
      end
      tapq_pkg::ST_Q_SB: begin
        sb_nxt = sum_rd;
        sum_ra = item_r.a;
        state_nxt = tapq_pkg::ST_Q_SA;
      end
      tapq_pkg::ST_Q_SA: begin
        plen_nxt = sb_r - sum_rd;
        hit_nxt = 1'b1;
        state_nxt = tapq_pkg::ST_Q_OUT;
      end
      tapq_pkg::ST_Q_OUT: begin
        if (hit_r) begin
          if (cnt_r != '1) cnt_nxt = cnt_r + 32'd1;
          tot_nxt = tot_r + plen_r;
        end
        ov_nxt = 1'b1; oh_nxt = hit_r; opl_nxt = plen_r;
        state_nxt = tapq_pkg::ST_IDLE;
      end
      default: state_nxt = tapq_pkg::ST_IDLE;
    endcase
  end

  assign clearing         = (state_r == tapq_pkg::ST_CLEAR);
  assign out_valid        = ov_r;
  assign out_on_path      = oh_r;
  assign out_path_length  = opl_r;
  assign out_match_count  = cnt_r;
  assign out_total_length = tot_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("result strobe held");
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oh_r) |-> (cnt_r != '0)) else $error("hit not counted");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= NW'(tapq_pkg::MAX_NODES)) else $error("walk stack overflow");
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ec_r <= NW'(tapq_pkg::EDGE_CAP)) else $error("edge store overflow");

endmodule
`default_nettype wire

[rtl/core/tree_ancestor_path_query.sv]
// tree_ancestor_path_query: top level joining the request front end and the
// query engine. Depends on tapq_pkg, tapq_front, tapq_back.
//
// After reset a clearing pass runs with busy high. An edge load writes both
// directions of the edge in the back end. A query that walks the lifting levels
// takes three steps per level over 11 levels: an ancestor table read, a depth
// read and the compare. A query that fails the range or depth checks skips the
// walk. The first query also runs the build: a depth-first walk of the edge
// slots with returns up the walk, then the ancestor table fill (10 levels of
// 1024 nodes). Two requests can queue; busy rises when the queue is full.
// Each result is a one-cycle out_valid strobe and cannot be held off by the
// receiver.
`default_nettype none
module tree_ancestor_path_query (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire                            in_mode,
  input  wire  [10:0]                    in_node_a,
  input  wire  [10:0]                    in_node_b,
  input  wire  signed [31:0]             in_weight,
  input  wire                            cfg_we,
  input  wire  [10:0]                    cfg_wdata,
  output logic                           out_valid,
  output logic                           out_on_path,
  output logic signed [63:0]             out_path_length,
  output logic [31:0]                    out_match_count,
  output logic signed [63:0]             out_total_length
);

  logic                 q_pop, q_valid, clearing;
  tapq_pkg::tapq_item_t q_item;

  tapq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_node_a     (in_node_a),
    .in_node_b     (in_node_b),
    .in_weight     (in_weight),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .back_clearing (clearing),
    .q_pop         (q_pop),
    .q_valid       (q_valid),
    .q_item        (q_item)
  );

  tapq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_on_path      (out_on_path),
    .out_path_length  (out_path_length),
    .out_match_count  (out_match_count),
    .out_total_length (out_total_length)
  );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking testbench for tree_ancestor_path_query. Loads a random tree,
// runs ancestor queries under several node counts and compares every result
// with a local predictor. Depends on tapq_pkg and the block's RTL only.
`timescale 1ns / 100ps

typedef struct {
  bit        on_path;
  bit [63:0] path_length;
  bit [31:0] match_count;
  bit [63:0] total_length;
} query_result_t;

class path_scoreboard;
  bit [10:0]     node_count;
  bit [10:0]     head[tapq_pkg::MAX_NODES+1];
  bit [10:0]     tgt[tapq_pkg::EDGE_CAP+1];
  bit [10:0]     nxt[tapq_pkg::EDGE_CAP+1];
  bit [63:0]     elen[tapq_pkg::EDGE_CAP+1];
  int unsigned   edges_used;
  bit [10:0]     depth[tapq_pkg::MAX_NODES+1];
  bit [63:0]     root_sum[tapq_pkg::MAX_NODES+1];
  bit [10:0]     anc[tapq_pkg::MAX_NODES+1][tapq_pkg::LIFT_LEVELS];
  bit            built;
  bit [31:0]     hits;
  bit [63:0]     total;
  query_result_t pending[$];
  int            errors;

  function new();
    node_count = 1;
  endfunction

  function int unsigned live_nodes();
    return (node_count > tapq_pkg::MAX_NODES) ? tapq_pkg::MAX_NODES : node_count;
  endfunction

  function void link(bit [10:0] from, bit [10:0] to, bit [63:0] w);
    edges_used++;
    tgt[edges_used]  = to;
    nxt[edges_used]  = head[from];
    elen[edges_used] = w;
    head[from]       = edges_used[10:0];
  endfunction

  function void build_tree();
    int unsigned wn[tapq_pkg::MAX_NODES+1];
    int unsigned we[tapq_pkg::MAX_NODES+1];
    int unsigned top, u, e, v;
    depth[1] = 1;
    wn[0] = 1;
    we[0] = 32'(head[1]);
    top = 1;
    while (top > 0) begin
      u = wn[top-1];
      e = we[top-1];
      if (e == 0 || e > tapq_pkg::EDGE_CAP) begin
        top--;
        continue;
      end
      we[top-1] = 32'(nxt[e]);
      v = 32'(tgt[e]);
      if (v == 0 || v > tapq_pkg::MAX_NODES || depth[v] != 0) continue;
      anc[v][0]   = 11'(u);
      root_sum[v] = root_sum[u] + elen[e];
      depth[v]    = 11'(depth[u] + 11'd1);
      if (top <= tapq_pkg::MAX_NODES) begin
        wn[top] = v;
        we[top] = 32'(head[v]);
        top++;
      end
    end
    for (int j = 1; j < tapq_pkg::LIFT_LEVELS; j++)
      for (int i = 1; i <= tapq_pkg::MAX_NODES; i++)
        anc[i][j] = anc[anc[i][j-1]][j-1];
    built = 1;
  endfunction

  // called for every accepted request
  function void note(bit mode, bit [10:0] a, bit [10:0] b, bit [31:0] w);
    int unsigned   n;
    bit [10:0]     x, up;
    query_result_t r;
    n = live_nodes();
    if (mode == 1'b0) begin
      if (built || a == 0 || b == 0 || a > n || b > n) return;
      if (edges_used + 2 > tapq_pkg::EDGE_CAP) return;
      link(a, b, {{32{w[31]}}, w});
      link(b, a, {{32{w[31]}}, w});
      return;
    end
    if (!built) build_tree();
    r = '{default: 0};
    if (a >= 1 && b >= 1 && a <= n && b <= n && depth[a] != 0 && depth[b] != 0 &&
        depth[a] <= depth[b]) begin
      x = b;
      for (int lv = tapq_pkg::LIFT_LEVELS - 1; lv >= 0; lv--) begin
        up = anc[x][lv];
        if (depth[up] >= depth[a]) x = up;
      end
      if (x == a) begin
        r.on_path     = 1;
        r.path_length = root_sum[b] - root_sum[a];
      end
    end
    if (r.on_path) begin
      if (hits != 32'hFFFF_FFFF) hits++;
      total += r.path_length;
    end
    r.match_count  = hits;
    r.total_length = total;
    pending.push_back(r);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check(bit on_path, bit [63:0] plen, bit [31:0] cnt, bit [63:0] tot);
    query_result_t r;
    if (pending.size() == 0) begin
      report("result with no query outstanding");
      return;
    end
    r = pending.pop_front();
    if (on_path != r.on_path) report($sformatf("on_path %0d exp %0d", on_path, r.on_path));
    if (plen != r.path_length)
      report($sformatf("path_length %h exp %h", plen, r.path_length));
    if (cnt != r.match_count)
      report($sformatf("match_count %0d exp %0d", cnt, r.match_count));
    if (tot != r.total_length)
      report($sformatf("total_length %h exp %h", tot, r.total_length));
  endtask
endclass

module tb_top;

  localparam bit MODE_EDGE  = 1'b0;
  localparam bit MODE_QUERY = 1'b1;
  localparam int TREE_NODES = 1000;
  localparam int CYCLE_LIMIT = 1000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic               in_mode = 0;
  logic [10:0]        in_node_a = 0;
  logic [10:0]        in_node_b = 0;
  logic signed [31:0] in_weight = 0;
  logic               cfg_we = 0;
  logic [10:0]        cfg_wdata = 0;
  logic               out_valid;
  logic               out_on_path;
  logic signed [63:0] out_path_length;
  logic [31:0]        out_match_count;
  logic signed [63:0] out_total_length;

  path_scoreboard sb = new();
  int             idle_pct = 0;
  int unsigned    cycles = 0;

  tree_ancestor_path_query i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_node_a(in_node_a), .in_node_b(in_node_b),
    .in_weight(in_weight), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_on_path(out_on_path),
    .out_path_length(out_path_length), .out_match_count(out_match_count),
    .out_total_length(out_total_length)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check(out_on_path, out_path_length, out_match_count, out_total_length);
  end

  task automatic send(bit mode, bit [10:0] a, bit [10:0] b, bit [31:0] w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start     <= 1;
    in_mode   <= mode;
    in_node_a <= a;
    in_node_b <= b;
    in_weight <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(mode, a, b, w);
  endtask

  // drain, let any edge load finish, then write the node count
  task automatic set_nodes(bit [10:0] n);
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
    sb.node_count = n;
  endtask

  function automatic bit [31:0] rand_weight();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_query();
    bit [10:0]   a, b;
    int unsigned n, k;
    n = sb.live_nodes();
    if ($urandom_range(9) < 8) begin
      b = 11'($urandom_range(1, n));
      for (int t = 0; t < 8 && sb.depth[b] == 0; t++) b = 11'($urandom_range(1, n));
      a = b;
      k = ($urandom_range(3) == 0) ? $urandom_range(0, 900) : $urandom_range(0, 6);
      while (k > 0 && sb.anc[a][0] != 0) begin
        a = sb.anc[a][0];
        k--;
      end
      if ($urandom_range(9) == 0) {a, b} = {b, a};
    end else begin
      a = 11'($urandom);
      b = 11'($urandom);
    end
    send(MODE_QUERY, a, b, $urandom);
  endtask

  initial begin
    bit [10:0] nodes[5];
    bit [10:0] p, q;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // node count 1: only a self-loop on the root fits
    idle_pct = 28;
    send(MODE_EDGE, 1, 1, 32'h0000_0005);
    send(MODE_EDGE, 1, 2, 32'h0000_0007);
    set_nodes(1024);
    send(MODE_EDGE, 0, 5, 32'h1);
    send(MODE_EDGE, 5, 0, 32'h1);
    send(MODE_EDGE, 2047, 3, 32'h1);
    send(MODE_EDGE, 1025, 2, 32'h1);
    for (int i = 2; i <= TREE_NODES; i++) begin
      p = ($urandom_range(3) == 0) ? 11'($urandom_range(1, i - 1)) : 11'(i - 1);
      q = 11'(i);
      if ($urandom_range(1)) send(MODE_EDGE, p, q, rand_weight());
      else send(MODE_EDGE, q, p, rand_weight());
    end
    send(MODE_EDGE, 2, 1, 32'h7FFF_FFFF);
    send(MODE_EDGE, 3, 7, 32'h8000_0000);
    // nodes above the tree stay unreached; the store fills up here
    for (int i = 0; i < 30; i++)
      send(MODE_EDGE, 11'($urandom_range(TREE_NODES + 1, 1024)),
           11'($urandom_range(TREE_NODES + 1, 1024)), rand_weight());

    send(MODE_QUERY, 1, 1, 32'hFFFF_FFFF);
    send(MODE_QUERY, 1, TREE_NODES, 0);
    send(MODE_QUERY, TREE_NODES, 1, 0);
    send(MODE_QUERY, 0, 3, 0);
    send(MODE_QUERY, 3, 0, 0);
    send(MODE_QUERY, 2047, 2047, 0);
    send(MODE_QUERY, 1024, 1024, 0);
    send(MODE_QUERY, 1, 1024, 0);
    send(MODE_QUERY, 5, 5, 0);
    send(MODE_QUERY, 3, 7, 0);
    send(MODE_EDGE, 1, 1024, 32'h1234);
    send(MODE_QUERY, 1, 1024, 0);

    nodes = '{2047, 1, 1024, 11'($urandom_range(2, 1023)), 1024};
    for (int ph = 0; ph < 5; ph++) begin
      set_nodes(nodes[ph]);
      idle_pct = (ph % 3 == 0) ? 28 : (ph % 3 == 1) ? 46 : 0;
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(19) == 0)
          send(MODE_EDGE, 11'($urandom), 11'($urandom), $urandom);
        random_query();
      end
    end

    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/tapq_pkg.sv
rtl/core/tapq_front.sv
rtl/core/tapq_back.sv
rtl/core/tree_ancestor_path_query.sv
sim/tb_top.sv
